/* rtl/sorted_id_list_set_ops_top_macros.svh */
// Assertion macros for the sorted id list set operations block.
`ifndef SORTED_ID_LIST_SET_OPS_TOP_MACROS_SVH
`define SORTED_ID_LIST_SET_OPS_TOP_MACROS_SVH
`ifndef SYNTH
`define SIL_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SIL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SIL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SIL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/silso_pkg.sv */
// ---------------------------------------------------------------------------
// silso_pkg
// Types and codes shared by the sorted id list set operations block.
// ---------------------------------------------------------------------------
package silso_pkg;
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_FETCH  = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] OP_UNION = 2'd0;
  localparam logic [1:0] OP_INTER = 2'd1;
  localparam logic [1:0] OP_DIFF  = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] id_value;
  } req_t;

  typedef struct packed {
    logic [31:0] result_id;
    logic        result_valid;
    logic        result_last;
    logic        overflow;
  } rsp_t;
endpackage

/* rtl/silso_if.sv */
// ---------------------------------------------------------------------------
// silso_req_if / silso_rsp_if
// Valid/ready channels for requests and results.
// ---------------------------------------------------------------------------
interface silso_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] id_value;
  modport source (output valid, mode, id_value, input ready);
  modport sink (input valid, mode, id_value, output ready);
endinterface

interface silso_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_id;
  logic        result_valid;
  logic        result_last;
  logic        overflow;
  modport source (output valid, result_id, result_valid, result_last, overflow,
                  input ready);
  modport sink (input valid, result_id, result_valid, result_last, overflow,
                output ready);
endinterface

/* rtl/silso_ram.sv */
// ---------------------------------------------------------------------------
// silso_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module silso_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/silso_front.sv */
// ---------------------------------------------------------------------------
// silso_front
// Two-entry request queue between the input channel and the engine.
// ---------------------------------------------------------------------------
module silso_front (
  input  logic             clk,
  input  logic             rst,
  silso_req_if.sink        req,
  output silso_pkg::req_t  q_data,
  output logic             q_valid,
  input  logic             q_pop
);
  import silso_pkg::*;

  req_t       slot [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       push;

  assign req.ready = (fill != 2'd2);
  assign push      = req.valid && req.ready;
  assign q_valid   = (fill != 2'd0);
  assign q_data    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{mode: req.mode, id_value: req.id_value};
    end
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

/* rtl/silso_back.sv */
// ---------------------------------------------------------------------------
// silso_back
// List storage and pointer walk engine; one request at a time.
// ---------------------------------------------------------------------------
module silso_back #(
  parameter int LIST_DEPTH = 1024
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      operation,
  input  silso_pkg::req_t q_data,
  input  logic            q_valid,
  output logic            q_pop,
  silso_rsp_if.source     rsp,
  output logic            busy
);
  import silso_pkg::*;

  localparam int AW = $clog2(LIST_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;  // addresses presented
  localparam logic [2:0] ST_EVAL = 3'd2;  // data present
  localparam logic [2:0] ST_OUT  = 3'd3;

  logic [2:0]    state;
  logic [CW-1:0] count_a, count_b, read_ptr_a, read_ptr_b;
  logic [CW-1:0] pa, pb;        // walk pointers
  logic          look;          // second walk: lookahead for last
  logic [31:0]   found_id;
  logic [31:0]   da, db;
  rsp_t          out_reg;
  logic          out_full;

  logic req_load_a, req_load_b;
  assign req_load_a = q_data.mode == MODE_LOAD_A && count_a != FULL;
  assign req_load_b = q_data.mode == MODE_LOAD_B && count_b != FULL;

  logic go;
  assign go = q_valid && state == ST_IDLE && !out_full;

  silso_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk(clk), .we(go && req_load_a), .waddr(count_a[AW-1:0]),
    .wdata(q_data.id_value), .raddr(pa[AW-1:0]), .rdata(da));
  silso_ram #(.WIDTH(32), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk(clk), .we(go && req_load_b), .waddr(count_b[AW-1:0]),
    .wdata(q_data.id_value), .raddr(pb[AW-1:0]), .rdata(db));

  assign q_pop = go;
  assign busy  = state != ST_IDLE || out_full;
  assign rsp.valid        = out_full;
  assign rsp.result_id    = out_reg.result_id;
  assign rsp.result_valid = out_reg.result_valid;
  assign rsp.result_last  = out_reg.result_last;
  assign rsp.overflow     = out_reg.overflow;

  logic in_a, in_b;
  assign in_a = pa < count_a;
  assign in_b = pb < count_b;

  // One evaluation step: produce hit / end / advance.
  logic          hit, done;
  logic [31:0]   hit_id;
  logic [CW-1:0] pa_n, pb_n;
  always_comb begin
    hit = 1'b0; done = 1'b0; hit_id = da; pa_n = pa; pb_n = pb;
    case (operation)
      OP_UNION: begin
        if (in_a && in_b) begin
          hit = 1'b1;
          if (da < db) begin
            pa_n = pa + 1'b1;
          end else if (da > db) begin
            hit_id = db; pb_n = pb + 1'b1;
          end else begin
            pa_n = pa + 1'b1; pb_n = pb + 1'b1;
          end
        end else if (in_a) begin
          hit = 1'b1; pa_n = pa + 1'b1;
        end else if (in_b) begin
          hit = 1'b1; hit_id = db; pb_n = pb + 1'b1;
        end else begin
          done = 1'b1;
        end
      end
      OP_INTER, OP_DIFF: begin
        if (!in_a) begin
          done = 1'b1;
        end else if (in_b && db < da) begin
          pb_n = pb + 1'b1;    // skip B entry
        end else begin
          pa_n = pa + 1'b1;
          hit  = ((in_b && db == da) == (operation == OP_INTER));
        end
      end
      default: done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; out_full <= 1'b0;
      count_a <= '0; count_b <= '0; read_ptr_a <= '0; read_ptr_b <= '0;
      pa <= '0; pb <= '0; look <= 1'b0;
    end else begin
      if (rsp.ready && out_full) out_full <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (go) begin
            case (q_data.mode)
              MODE_LOAD_A: begin
                if (req_load_a) count_a <= count_a + 1'b1;
                else begin
                  out_reg <= '{32'd0, 1'b0, 1'b0, 1'b1}; out_full <= 1'b1;
                end
              end
              MODE_LOAD_B: begin
                if (req_load_b) count_b <= count_b + 1'b1;
                else begin
                  out_reg <= '{32'd0, 1'b0, 1'b0, 1'b1}; out_full <= 1'b1;
                end
              end
              MODE_FETCH: begin
                pa <= read_ptr_a; pb <= read_ptr_b; look <= 1'b0;
                state <= ST_READ;
              end
              default: begin
                count_a <= '0; count_b <= '0; read_ptr_a <= '0; read_ptr_b <= '0;
              end
            endcase
          end
        end
        ST_READ: state <= ST_EVAL;
        ST_EVAL: begin
          pa <= pa_n; pb <= pb_n;
          if (done) begin
            if (!look) out_reg <= '{32'd0, 1'b0, 1'b1, 1'b0};
            else out_reg <= '{found_id, 1'b1, 1'b1, 1'b0};
            state <= ST_OUT;
          end else if (hit) begin
            if (!look) begin
              found_id <= hit_id;
              read_ptr_a <= pa_n; read_ptr_b <= pb_n;
              look <= 1'b1; state <= ST_READ;
            end else begin
              out_reg <= '{found_id, 1'b1, 1'b0, 1'b0};
              state <= ST_OUT;
            end
          end else begin
            state <= ST_READ;
          end
        end
        ST_OUT: begin
          out_full <= 1'b1; state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

/* rtl/sorted_id_list_set_ops_top.sv */
// Sorted id list set operations.
// Requests arrive on req (valid/ready): mode 0/1 loads id_value into list A/B,
// mode 2 fetches the next id of the set chosen by the operation register
// (0 union, 1 intersection, 2 A minus B), mode 3 clears both lists.
// Results leave on rsp (valid/ready): one per fetch, and one per load that
// hits a full list (overflow set). Other loads and clears give no result.
// A two-entry queue takes requests while the engine works.
// A load is handled in the engine's idle state. A fetch walks the list
// entries in turn (registered RAM read, then compare), covering both the
// returned id and the lookahead for result_last, then delivers via ST_OUT.
// Reset clears counts, pointers and the operation register; the list RAMs
// need no clearing. While the receiver stalls the result register holds and
// the engine waits; the queue still takes up to two requests.
// Write cfg_we/cfg_data only while idle.
module sorted_id_list_set_ops_top #(
  parameter int LIST_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  silso_req_if.sink   req,
  silso_rsp_if.source rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data
);
  import silso_pkg::*;
`include "sorted_id_list_set_ops_top_macros.svh"

  logic [1:0] operation;
  req_t       q_data;
  logic       q_valid, q_pop, busy;

  always_ff @(posedge clk) begin
    if (rst) operation <= OP_UNION;
    else if (cfg_we) operation <= cfg_data;
  end

  silso_front u_front (
    .clk(clk), .rst(rst), .req(req), .q_data(q_data), .q_valid(q_valid),
    .q_pop(q_pop));

  silso_back #(.LIST_DEPTH(LIST_DEPTH)) u_back (
    .clk(clk), .rst(rst), .operation(operation), .q_data(q_data),
    .q_valid(q_valid), .q_pop(q_pop), .rsp(rsp), .busy(busy));

  `SIL_ASSERT_IMPL(a_pop_needs_valid, clk, rst, q_pop, q_valid)
  `SIL_ASSERT_IMPL(a_pop_not_busy, clk, rst, q_pop, !busy)
  `SIL_ASSERT_IMPL(a_ovf_not_valid, clk, rst, rsp.valid && rsp.overflow,
                   !rsp.result_valid)
  `SIL_ASSERT_NEXT(a_rsp_holds, clk, rst, rsp.valid && !rsp.ready,
                   rsp.valid && $stable(rsp.result_id))
endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: sorted id list set operations bench
// Loads ascending id lists into A and B, fetches union, intersection and
// difference results under changing operations, and checks every result
// against a scoreboard that walks its own copy of both lists. Also covers
// unsorted lists, the unused operation code and overflow of a full list.
// ---------------------------------------------------------------------------
module tb_top;
  import silso_pkg::*;

  localparam int DEPTH = 1024;

  class set_ops_scoreboard;
    logic [31:0] list_a [DEPTH];
    logic [31:0] list_b [DEPTH];
    int unsigned cnt_a, cnt_b, ptr_a, ptr_b;
    logic [1:0]  op;
    rsp_t        expected_q[$];
    int          errors, fetches, hits, overflows;

    function bit find_next(int unsigned pa, int unsigned pb, output logic [31:0] id,
                           output int unsigned npa, output int unsigned npb);
      bit want, match;
      logic [31:0] a;
      id = '0; npa = pa; npb = pb;
      if (op == OP_UNION) begin
        if (pa < cnt_a && pb < cnt_b) begin
          if (list_a[pa] < list_b[pb]) begin
            id = list_a[pa]; pa++;
          end else if (list_a[pa] > list_b[pb]) begin
            id = list_b[pb]; pb++;
          end else begin
            id = list_a[pa]; pa++; pb++;
          end
        end else if (pa < cnt_a) begin
          id = list_a[pa]; pa++;
        end else if (pb < cnt_b) begin
          id = list_b[pb]; pb++;
        end else begin
          return 0;
        end
        npa = pa; npb = pb;
        return 1;
      end
      if (op == OP_INTER || op == OP_DIFF) begin
        want = (op == OP_INTER);
        while (pa < cnt_a) begin
          a = list_a[pa];
          while (pb < cnt_b && list_b[pb] < a) pb++;
          match = (pb < cnt_b) && (list_b[pb] == a);
          pa++;
          if (match == want) begin
            id = a; npa = pa; npb = pb;
            return 1;
          end
        end
      end
      return 0;
    endfunction

    function void note_request(logic [1:0] mode, logic [31:0] idv);
      rsp_t r;
      logic [31:0] id, id2;
      int unsigned npa, npb, lpa, lpb;
      r = '0;
      case (mode)
        MODE_LOAD_A, MODE_LOAD_B: begin
          if (mode == MODE_LOAD_A && cnt_a < DEPTH) begin
            list_a[cnt_a] = idv; cnt_a++;
          end else if (mode == MODE_LOAD_B && cnt_b < DEPTH) begin
            list_b[cnt_b] = idv; cnt_b++;
          end else begin
            r.overflow = 1'b1;
            overflows++;
            expected_q.push_back(r);
          end
        end
        MODE_FETCH: begin
          fetches++;
          if (find_next(ptr_a, ptr_b, id, npa, npb)) begin
            ptr_a = npa; ptr_b = npb;
            r.result_id = id;
            r.result_valid = 1'b1;
            r.result_last = !find_next(ptr_a, ptr_b, id2, lpa, lpb);
            hits++;
          end else begin
            r.result_last = 1'b1;
          end
          expected_q.push_back(r);
        end
        default: begin
          cnt_a = 0; cnt_b = 0; ptr_a = 0; ptr_b = 0;
        end
      endcase
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      exp = expected_q.pop_front();
      if (got.result_id !== exp.result_id)
        report($sformatf("result_id %h, want %h", got.result_id, exp.result_id));
      if (got.result_valid !== exp.result_valid)
        report($sformatf("result_valid %b, want %b", got.result_valid, exp.result_valid));
      if (got.result_last !== exp.result_last)
        report($sformatf("result_last %b, want %b", got.result_last, exp.result_last));
      if (got.overflow !== exp.overflow)
        report($sformatf("overflow %b, want %b", got.overflow, exp.overflow));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_data = OP_UNION;

  silso_req_if req ();
  silso_rsp_if rsp ();

  sorted_id_list_set_ops_top #(.LIST_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  set_ops_scoreboard sb = new();
  int items_sent;
  int burst_left;
  int stall_cycle;
  int stall_style;
  bit op_seen [4];

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_CLEAR;
    req.id_value = '0;
    rsp.ready = 1'b0;
  end

  // Result side: check accepted results, stall on one of four patterns, redrawn at random as the run goes on.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_cycle <= 0;
      stall_style <= 0;
    end else begin
      if (rsp.valid && rsp.ready)
        sb.check_result({rsp.result_id, rsp.result_valid, rsp.result_last, rsp.overflow});
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle % 150 == 0) stall_style <= $urandom_range(0, 3);
      case (stall_style)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(0, 9) < 7);
        2: rsp.ready <= (stall_cycle % 16 > 11);
        default: rsp.ready <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  task send(logic [1:0] mode, logic [31:0] idv);
    if (burst_left == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    req.valid <= 1'b1;
    req.mode <= mode;
    req.id_value <= idv;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_request(mode, idv);
    burst_left--;
    items_sent++;
  endtask

  // Hold the sender until every expected result is back, then let queued loads drain.
  task drain();
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task write_op(logic [1:0] op);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= op;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.op = op;
    op_seen[op] = 1'b1;
  endtask

  task random_phase();
    logic [31:0] a_ids[$], b_ids[$];
    logic [31:0] v;
    int na, nb, ia, ib, nf;
    bit unsorted, wide;
    write_op($urandom_range(0, 7) == 0 ? 2'd3 : 2'($urandom_range(0, 2)));
    send(MODE_CLEAR, $urandom());
    na = $urandom_range(0, 20);
    nb = $urandom_range(0, 20);
    unsorted = ($urandom_range(0, 9) == 0);
    wide = ($urandom_range(0, 3) == 0);
    v = wide ? $urandom() : $urandom_range(0, 40);
    // Draw both lists from one ascending walk so they overlap often.
    while (a_ids.size() < na || b_ids.size() < nb) begin
      v += wide ? $urandom_range(0, 32'h0800_0000) : $urandom_range(0, 3);
      if (unsorted) v = $urandom();
      if (a_ids.size() < na && $urandom_range(0, 2) != 0) a_ids.push_back(v);
      if (b_ids.size() < nb && $urandom_range(0, 2) != 0) b_ids.push_back(v);
    end
    ia = 0; ib = 0;
    while (ia < na || ib < nb) begin
      if (ib >= nb || (ia < na && $urandom_range(0, 1))) begin
        send(MODE_LOAD_A, a_ids[ia]); ia++;
      end else begin
        send(MODE_LOAD_B, b_ids[ib]); ib++;
      end
      if ($urandom_range(0, 9) == 0) send(MODE_FETCH, $urandom());
    end
    nf = na + nb + $urandom_range(1, 2);
    for (int i = 0; i < nf; i++) begin
      if (i == nf / 2 && $urandom_range(0, 4) == 0) write_op(2'($urandom_range(0, 2)));
      send(MODE_FETCH, $urandom());
    end
  endtask

  initial begin
    items_sent = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: id extremes, equal heads, union walk and exhausted fetches.
    write_op(OP_UNION);
    send(MODE_LOAD_A, 32'h0000_0000);
    send(MODE_LOAD_A, 32'h0000_0005);
    send(MODE_LOAD_A, 32'h8000_0000);
    send(MODE_LOAD_A, 32'hFFFF_FFFF);
    send(MODE_LOAD_B, 32'h0000_0005);
    send(MODE_LOAD_B, 32'h7FFF_FFFF);
    send(MODE_LOAD_B, 32'hFFFF_FFFF);
    repeat (7) send(MODE_FETCH, 32'hFFFF_FFFF);
    write_op(OP_INTER);
    send(MODE_CLEAR, 32'h0);
    send(MODE_LOAD_A, 32'h8000_0000);
    send(MODE_LOAD_B, 32'h7FFF_FFFF);
    send(MODE_LOAD_B, 32'h8000_0000);
    repeat (2) send(MODE_FETCH, 32'h0);
    write_op(OP_DIFF);
    send(MODE_CLEAR, 32'h0);
    send(MODE_LOAD_A, 32'h1);
    send(MODE_LOAD_A, 32'h2);
    send(MODE_LOAD_B, 32'h2);
    repeat (2) send(MODE_FETCH, 32'h0);

    while (items_sent < 400) random_phase();

    // Fill list A past capacity, add a short list B, then walk a few union results.
    write_op(OP_UNION);
    send(MODE_CLEAR, 32'h0);
    for (int i = 0; i < DEPTH + 2; i++) send(MODE_LOAD_A, 32'(i * 3));
    for (int i = 0; i < 8; i++) send(MODE_LOAD_B, 32'(i * 5));
    repeat (4) send(MODE_FETCH, 32'h0);

    while (items_sent < 1950) random_phase();

    drain();
    $display("Sent %0d requests: %0d fetches (%0d ids), %0d overflows.",
             items_sent, sb.fetches, sb.hits, sb.overflows);
    $display("Operations used: union %0b, intersection %0b, difference %0b, unused %0b.",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

/* sorted_id_list_set_ops_top.f */
+incdir+rtl
rtl/silso_pkg.sv
rtl/silso_if.sv
rtl/silso_ram.sv
rtl/silso_front.sv
rtl/silso_back.sv
rtl/sorted_id_list_set_ops_top.sv
bench/tb_top.sv
